// ----- rtl/ludec_pkg.sv -----
// ----------------------------------------------------------------------------
// ludec_pkg
// Types, constants and decode functions shared by the lenient UTF-8 decoder.
// ----------------------------------------------------------------------------
package ludec_pkg;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

    // sequence lengths reported for a lead byte
    localparam logic [2:0] LEN_INVALID = 3'd0;
    localparam logic [2:0] LEN_ONE     = 3'd1;
    localparam logic [2:0] LEN_TWO     = 3'd2;
    localparam logic [2:0] LEN_THREE   = 3'd3;
    localparam logic [2:0] LEN_FOUR    = 3'd4;

    // lead byte masks and patterns
    localparam logic [7:0] MASK_TWO    = 8'hE0;
    localparam logic [7:0] PAT_TWO     = 8'hC0;
    localparam logic [7:0] MASK_THREE  = 8'hF0;
    localparam logic [7:0] PAT_THREE   = 8'hE0;
    localparam logic [7:0] MASK_FOUR   = 8'hF8;
    localparam logic [7:0] PAT_FOUR    = 8'hF0;

    // one decoded code point and its end-of-string mark
    typedef struct packed {
        logic [20:0] cp;
        logic        last;
    } result_t;

    // all results of one input byte
    typedef struct packed {
        logic [1:0]            count;
        result_t [2:0]         res;
    } decode_t;

    typedef logic [3:0][7:0] byte_buf_t;

    // sequence length of a lead byte
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b[7] == 1'b0) begin
            len = LEN_ONE;
        end else if ((b & MASK_TWO) == PAT_TWO) begin
            len = LEN_TWO;
        end else if ((b & MASK_THREE) == PAT_THREE) begin
            len = LEN_THREE;
        end else if ((b & MASK_FOUR) == PAT_FOUR) begin
            len = LEN_FOUR;
        end else begin
            len = LEN_INVALID;
        end
        return len;
    endfunction

    // merge a sequence of len bytes (2..4) starting at position start
    function automatic logic [20:0] merge_seq(input byte_buf_t bytes,
                                              input logic [1:0] start,
                                              input logic [2:0] len);
        logic [20:0] cp;
        logic [7:0]  lead;
        logic [1:0]  pos;
        lead = bytes[start];
        if (len == LEN_TWO) begin
            cp = {16'd0, lead[4:0]};
        end else if (len == LEN_THREE) begin
            cp = {17'd0, lead[3:0]};
        end else begin
            cp = {18'd0, lead[2:0]};
        end
        for (int k = 1; k < 4; k++) begin
            pos = start + 2'(k);
            if (3'(k) < len) begin
                cp = {cp[14:0], bytes[pos][5:0]};
            end
        end
        return cp;
    endfunction

    // decode a final block of n (1..4) bytes into at most three results
    function automatic decode_t decode_block(input byte_buf_t bytes,
                                             input logic [2:0] n);
        decode_t     d;
        logic [2:0]  i;
        logic [2:0]  len;
        logic [3:0]  reach;
        logic [2:0]  step;
        logic [20:0] cp;
        logic [7:0]  b;
        d     = '0;
        i     = 3'd0;
        for (int k = 0; k < 3; k++) begin
            if (i < n) begin
                b     = bytes[i[1:0]];
                len   = lead_length(b);
                reach = {1'b0, i} + {1'b0, len};
                step  = 3'd1;
                if (len == LEN_ONE) begin
                    cp = {13'd0, b};
                end else if (len >= LEN_TWO && reach <= {1'b0, n}) begin
                    cp   = merge_seq(bytes, i[1:0], len);
                    step = len;
                end else begin
                    cp = REPLACEMENT_CP;
                end
                i               = i + step;
                d.res[k].cp     = cp;
                d.res[k].last   = (i >= n);
                d.count         = 2'(k + 1);
            end
        end
        return d;
    endfunction

endpackage

// ----- rtl/lenient_utf8_decoder.sv -----
// ----------------------------------------------------------------------------
// lenient_utf8_decoder
// UTF-8 byte stream to code points, checking lead bytes only.
// ----------------------------------------------------------------------------
// One byte is taken per cycle and decoded in a single registered pass into a
// four-entry result queue; a code point leaves the queue on every m_ transfer.
// A byte that ends a sequence or stands alone gives one code point, a byte
// inside a sequence gives none, and the final byte of a string (s_tlast) can
// give up to three when an unfinished sequence is flushed. s_tready is high
// while the queue holds at most one result, so a plain stream runs at one byte
// per cycle while m_tready stays high; after an end-of-string flush the input
// waits while the extra code points drain through the output port.
module lenient_utf8_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_tlast    // last_point
);

    ludec_pkg::result_t [3:0] queue_reg, queue_next;
    logic [2:0]               cnt_reg, cnt_next;
    logic [2:0][7:0]          held_reg, held_next;
    logic [1:0]               hc_reg, hc_next;
    logic [2:0]               need_reg, need_next;

    logic                     push;
    logic                     pop;
    logic [2:0]               base;
    logic [2:0]               slot_ofs;
    ludec_pkg::byte_buf_t     bytes;
    ludec_pkg::decode_t       dec;
    logic [2:0]               lead_len;
    logic [2:0]               seq_len;

    // handshake
    assign s_tready = (cnt_reg <= 3'd1);
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = {3'd0, queue_reg[0].cp};
    assign m_tlast  = queue_reg[0].last;
    assign push     = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    // held bytes followed by the new byte
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (2'(k) < hc_reg && k < 3) begin
                bytes[k] = held_reg[k[1:0]];
            end else if (k == int'(hc_reg)) begin
                bytes[k] = s_tdata;
            end else begin
                bytes[k] = 8'h00;
            end
        end
    end

    assign lead_len = ludec_pkg::lead_length(s_tdata);
    assign seq_len  = {1'b0, hc_reg} + 3'd1;

    // decode and state update for one byte
    always_comb begin
        dec       = '0;
        held_next = held_reg;
        hc_next   = hc_reg;
        need_next = need_reg;
        if (s_tlast) begin
            dec       = ludec_pkg::decode_block(bytes, seq_len);
            hc_next   = 2'd0;
            need_next = 3'd0;
        end else if (hc_reg == 2'd0) begin
            if (lead_len == ludec_pkg::LEN_ONE) begin
                dec.count     = 2'd1;
                dec.res[0].cp = {13'd0, s_tdata};
            end else if (lead_len == ludec_pkg::LEN_INVALID) begin
                dec.count     = 2'd1;
                dec.res[0].cp = ludec_pkg::REPLACEMENT_CP;
            end else begin
                held_next[0] = s_tdata;
                hc_next      = 2'd1;
                need_next    = lead_len;
            end
        end else if (seq_len >= need_reg || hc_reg == 2'd3) begin
            dec.count     = 2'd1;
            dec.res[0].cp = ludec_pkg::merge_seq(bytes, 2'd0, seq_len);
            hc_next       = 2'd0;
            need_next     = 3'd0;
        end else begin
            held_next[hc_reg] = s_tdata;
            hc_next           = hc_reg + 2'd1;
        end
    end

    // result queue: shift out at the head, append new results after the rest
    assign base = cnt_reg - {2'd0, pop};

    always_comb begin
        queue_next = queue_reg;
        if (pop) begin
            for (int j = 0; j < 3; j++) begin
                queue_next[j] = queue_reg[j + 1];
            end
        end
        for (int j = 0; j < 4; j++) begin
            slot_ofs = 3'(j) - base;
            if (push && 3'(j) >= base && slot_ofs < {1'b0, dec.count}) begin
                queue_next[j] = dec.res[slot_ofs[1:0]];
            end
        end
        cnt_next = base + (push ? {1'b0, dec.count} : 3'd0);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 3'd0;
            hc_reg   <= 2'd0;
            need_reg <= 3'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                hc_reg   <= hc_next;
                need_reg <= need_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        queue_reg <= queue_next;
        if (push) begin
            held_reg <= held_next;
        end
    end

endmodule

// ----- rtl/ludec_checker.sv -----
// ----------------------------------------------------------------------------
// ludec_checker
// Port-level checks for the lenient UTF-8 decoder, bound to lenient_utf8_decoder.
// ----------------------------------------------------------------------------
module ludec_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // reset empties the result queue
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // an empty queue always takes input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result queue");

    // the final byte of a string always yields a code point
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no code point after end of string");

    // code points never exceed 21 bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:21] == 3'd0)
        else $error("padding bits set in result");

endmodule

bind lenient_utf8_decoder ludec_checker u_ludec_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
